>>> hdl/qwcm_pkg.sv
// ----------------------------------------------------------------------------
// qwcm_pkg
// Shared types and constants for the queue watermark crossing monitor.
// ----------------------------------------------------------------------------
package qwcm_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int NUM_MARKS      = 3;

    localparam int CHAN_W  = 2;
    localparam int QID_W   = 14;
    localparam int FILL_W  = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [FILL_W-1:0] MARK_MIN_RST  = 16'd64;
    localparam logic [FILL_W-1:0] MARK_LOW_RST  = 16'd128;
    localparam logic [FILL_W-1:0] MARK_HIGH_RST = 16'd256;

    // register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_MARK_MIN  = 2'd1,
        REG_MARK_LOW  = 2'd2,
        REG_MARK_HIGH = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [QID_W-1:0]  queue_id;
        logic [FILL_W-1:0] fill_count;
    } in_item_t;

    typedef struct packed {
        logic [QID_W-1:0]  rec_queue_id;
        logic [FILL_W-1:0] rec_count;
        logic              last_record;
    } out_item_t;

    typedef struct packed {
        logic              enable;
        logic [FILL_W-1:0] mark_min;
        logic [FILL_W-1:0] mark_low;
        logic [FILL_W-1:0] mark_high;
    } cfg_t;

    // one classified item: which marks were crossed (bit 0 = min)
    typedef struct packed {
        logic [QID_W-1:0]     qid;
        logic [FILL_W-1:0]    count;
        logic [NUM_MARKS-1:0] hits;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

endpackage

>>> hdl/qwcm_front.sv
// ----------------------------------------------------------------------------
// qwcm_front
// Accepts count reports, checks the three marks against the channel's
// recorded count and, while enabled, pushes items with at least one crossing.
// ----------------------------------------------------------------------------
module qwcm_front #(
    parameter int CHANNELS   = qwcm_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = qwcm_pkg::COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qwcm_pkg::in_item_t s_data,
    input  qwcm_pkg::cfg_t    cfg,
    input  logic              q_full,
    output qwcm_pkg::push_t   push
);

    logic [COUNT_BITS-1:0] rec_reg  [CHANNELS];
    logic [COUNT_BITS-1:0] rec_next [CHANNELS];
    logic [COUNT_BITS-1:0] prev_count;
    logic [COUNT_BITS-1:0] now;
    logic [COUNT_BITS-1:0] lvl_min;
    logic [COUNT_BITS-1:0] lvl_low;
    logic [COUNT_BITS-1:0] lvl_high;
    logic [qwcm_pkg::NUM_MARKS-1:0] hits;
    logic [CHANNELS-1:0]   ch_sel;
    logic                  accept;

    function automatic logic crossed(input logic [COUNT_BITS-1:0] level,
                                     input logic [COUNT_BITS-1:0] prev,
                                     input logic [COUNT_BITS-1:0] cur);
        crossed = (cur < level && prev > level) || (cur > level && prev < level);
    endfunction

    // counts and marks wrap to COUNT_BITS
    assign now      = COUNT_BITS'({16'b0, s_data.fill_count});
    assign lvl_min  = COUNT_BITS'({16'b0, cfg.mark_min});
    assign lvl_low  = COUNT_BITS'({16'b0, cfg.mark_low});
    assign lvl_high = COUNT_BITS'({16'b0, cfg.mark_high});

    always_comb begin
        prev_count = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            ch_sel[i] = (int'(s_data.channel) == i);
            if (ch_sel[i]) begin
                prev_count = rec_reg[i];
            end
        end
    end

    assign hits[0] = crossed(lvl_min,  prev_count, now);
    assign hits[1] = crossed(lvl_low,  prev_count, now);
    assign hits[2] = crossed(lvl_high, prev_count, now);

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign push.valid       = accept && cfg.enable && (ch_sel != '0) && (hits != '0);
    assign push.entry.qid   = s_data.queue_id;
    assign push.entry.count = 16'(32'(now));
    assign push.entry.hits  = hits;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            rec_next[i] = (push.valid && ch_sel[i]) ? now : rec_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                rec_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < CHANNELS; i++) begin
                rec_reg[i] <= rec_next[i];
            end
        end
    end

    a_push_has_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (push.entry.hits != '0) && s_ready)
        else $error("push without crossing or while full");

endmodule

>>> hdl/qwcm_fifo.sv
// ----------------------------------------------------------------------------
// qwcm_fifo
// Short flop queue between the classifier and the record emitter.
// ----------------------------------------------------------------------------
module qwcm_fifo #(
    parameter int DEPTH = qwcm_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  qwcm_pkg::push_t   push,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output qwcm_pkg::entry_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qwcm_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !full)
        else $error("entry pushed into full queue");

endmodule

>>> hdl/qwcm_back.sv
// ----------------------------------------------------------------------------
// qwcm_back
// Expands one queued entry into one record per crossed mark, min first.
// ----------------------------------------------------------------------------
module qwcm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  qwcm_pkg::entry_t    head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output qwcm_pkg::out_item_t m_data
);

    localparam int NM = qwcm_pkg::NUM_MARKS;

    logic                 work_valid_reg, work_valid_next;
    qwcm_pkg::entry_t     work_reg, work_next;
    logic                 out_valid_reg, out_valid_next;
    qwcm_pkg::out_item_t  out_reg, out_next;
    logic [NM-1:0]        sel;
    logic [NM-1:0]        rest;
    logic                 out_free;
    logic                 emit;
    logic                 last;

    assign out_free = !out_valid_reg || m_ready;
    assign emit     = work_valid_reg && out_free;
    assign sel      = work_reg.hits & (~work_reg.hits + NM'(1));   // lowest set bit
    assign rest     = work_reg.hits & ~sel;
    assign last     = (rest == '0);
    assign pop      = head_valid && (!work_valid_reg || (emit && last));

    always_comb begin
        work_valid_next = work_valid_reg;
        work_next       = work_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next        = 1'b1;
            out_next.rec_queue_id = work_reg.qid;
            out_next.rec_count    = work_reg.count;
            out_next.last_record  = last;
            work_next.hits        = rest;
            if (last) begin
                work_valid_next = 1'b0;
            end
        end
        if (pop) begin
            work_valid_next = 1'b1;
            work_next       = head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_work_has_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        work_valid_reg |-> (work_reg.hits != '0))
        else $error("working entry with no crossing left");

    a_last_retires: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last && !pop) |=> !work_valid_reg)
        else $error("entry not retired after its last record");

endmodule

>>> hdl/queue_watermark_crossing_monitor.sv
// ----------------------------------------------------------------------------
// queue_watermark_crossing_monitor
// Checks per-channel queue fill counts against three watermarks and emits
// one record per crossing.
// ----------------------------------------------------------------------------
// Path: entry queue, then the emitter's work register, then the output register.
// Throughput: one report accepted per cycle while the entry queue has room;
//   the record emitter gives one record per cycle while the receiver is ready,
//   one per crossing (items without crossing cost it nothing).
// Reset (aresetn low, synchronous): recorded counts cleared, monitor
//   disabled, marks back to 64/128/256, queue and output emptied.
// ----------------------------------------------------------------------------
module queue_watermark_crossing_monitor #(
    parameter int CHANNELS   = qwcm_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = qwcm_pkg::COUNT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // report channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  qwcm_pkg::in_item_t          s_data,
    // record channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output qwcm_pkg::out_item_t         m_data,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qwcm_pkg::ADDR_W-1:0] paddr,
    input  logic [qwcm_pkg::DATA_W-1:0] pwdata,
    output logic [qwcm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    // Register file. Writes land on the access phase; reads are combinational.
    qwcm_pkg::cfg_t    cfg_reg, cfg_next;
    qwcm_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = qwcm_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                qwcm_pkg::REG_ENABLE:    cfg_next.enable    = pwdata[0];
                qwcm_pkg::REG_MARK_MIN:  cfg_next.mark_min  = pwdata[15:0];
                qwcm_pkg::REG_MARK_LOW:  cfg_next.mark_low  = pwdata[15:0];
                qwcm_pkg::REG_MARK_HIGH: cfg_next.mark_high = pwdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            qwcm_pkg::REG_ENABLE:    prdata = {31'b0, cfg_reg.enable};
            qwcm_pkg::REG_MARK_MIN:  prdata = {16'b0, cfg_reg.mark_min};
            qwcm_pkg::REG_MARK_LOW:  prdata = {16'b0, cfg_reg.mark_low};
            qwcm_pkg::REG_MARK_HIGH: prdata = {16'b0, cfg_reg.mark_high};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable    <= 1'b0;
            cfg_reg.mark_min  <= qwcm_pkg::MARK_MIN_RST;
            cfg_reg.mark_low  <= qwcm_pkg::MARK_LOW_RST;
            cfg_reg.mark_high <= qwcm_pkg::MARK_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify and update the recorded count in the accept cycle, so
    // a back-to-back report on the same channel sees the new value.
    qwcm_pkg::push_t  push;
    logic             q_full;
    logic             q_pop;
    logic             q_head_valid;
    qwcm_pkg::entry_t q_head;

    qwcm_front #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .push    (push)
    );

    // Entry queue decouples classification from record emission.
    qwcm_fifo #(
        .DEPTH (qwcm_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Back: one record per crossed mark, through a registered output.
    qwcm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> tb/queue_watermark_crossing_monitor_test.sv
// ----------------------------------------------------------------------------
// queue_watermark_crossing_monitor_test
// Drives fill-count reports into the monitor and checks every crossing record
// against a cycle-free predictor. A short directed table covers the disabled
// monitor, counts equal to a mark, extreme counts and marks, and several
// crossings in one report. Random phases follow, each with new marks and,
// outside the calm ones, random gaps on both sides; one adds a long back-pressure hold.
// ----------------------------------------------------------------------------
module queue_watermark_crossing_monitor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qwcm_pkg::*;

    // Run shape
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 24;
    localparam int LONG_HOLD   = 80;   // receiver stall that fills the entry queue
    localparam int SETTLE      = 8;    // margin after the last expected record
    localparam int PREDICT     = -1;   // table row checked by the predictor only

    typedef enum logic {
        ROW_REPORT,
        ROW_REG
    } row_kind_t;

    // One line of the directed table. typed_n is the number of records that
    // the report must give, or PREDICT when the predictor decides.
    typedef struct {
        row_kind_t           kind;
        reg_idx_t            idx;
        logic [DATA_W-1:0]   value;
        logic [CHAN_W-1:0]   ch;
        logic [QID_W-1:0]    qid;
        logic [FILL_W-1:0]   fill;
        int                  typed_n;
    } row_t;

    localparam int ROWS = 27;

    row_t plan [ROWS] = '{
        // reset leaves the monitor off: report is dropped
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd0, 14'd1,     16'd300,   0},
        '{ROW_REG,    REG_ENABLE,    32'd1,     2'd0, 14'd0,     16'd0,     0},
        // marks 64/128/256, every channel starts at zero
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd0, 14'd0,     16'd0,     0},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd0, 14'd16383, 16'd65535, 3},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd0, 14'd5,     16'd0,     3},
        // count lands on a mark: no crossing, recorded count kept
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd1, 14'd7,     16'd64,    0},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd1, 14'd7,     16'd100,   1},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd1, 14'd7,     16'd128,   0},
        // recorded count sits on the low mark, only high is crossed
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd2, 14'd9,     16'd128,   1},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd2, 14'd9,     16'd300,   1},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd3, 14'd12,    16'd200,   2},
        // extreme marks: 0 and 65535 can never be crossed
        '{ROW_REG,    REG_MARK_MIN,  32'd0,     2'd0, 14'd0,     16'd0,     0},
        '{ROW_REG,    REG_MARK_LOW,  32'd65535, 2'd0, 14'd0,     16'd0,     0},
        '{ROW_REG,    REG_MARK_HIGH, 32'd1,     2'd0, 14'd0,     16'd0,     0},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd0, 14'd3,     16'd65535, 1},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd0, 14'd3,     16'd1,     0},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd0, 14'd3,     16'd0,     1},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd1, 14'd8,     16'd65535, 0},
        // disabled again: state must survive untouched
        '{ROW_REG,    REG_ENABLE,    32'd0,     2'd0, 14'd0,     16'd0,     0},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd2, 14'd9,     16'd0,     0},
        '{ROW_REG,    REG_ENABLE,    32'd1,     2'd0, 14'd0,     16'd0,     0},
        '{ROW_REG,    REG_MARK_MIN,  32'd64,    2'd0, 14'd0,     16'd0,     0},
        '{ROW_REG,    REG_MARK_LOW,  32'd128,   2'd0, 14'd0,     16'd0,     0},
        '{ROW_REG,    REG_MARK_HIGH, 32'd256,   2'd0, 14'd0,     16'd0,     0},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd2, 14'd9,     16'd0,     PREDICT},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd3, 14'd10922, 16'd129,   PREDICT},
        '{ROW_REPORT, REG_ENABLE,    32'd0,     2'd1, 14'd5461,  16'd63,    PREDICT}
    };

    // DUT signals
    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predictor state: shadow registers and last recorded count per channel
    cfg_t                shadow_cfg;
    logic [FILL_W-1:0]   last_count [CHANNELS_DEF];
    out_item_t           pending_records [$];

    // Bookkeeping
    int  mismatches      = 0;
    int  words_sent      = 0;
    int  records_checked = 0;
    int  settings        = 0;
    bit  calm            = 1'b0;   // phase with no random gaps on either side
    int  hold_asked      = 0;      // bumped by stimulus, served by the receiver

    queue_watermark_crossing_monitor uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("timeout: %0d records still pending", pending_records.size());
        $display("== FAIL ==");
        $finish;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Counts are aimed around the current marks so that crossings and
    // exact hits are frequent; the rest are zero, all ones, full-range or below 512.
    function automatic logic [FILL_W-1:0] pick_fill();
        int                roll;
        logic [FILL_W-1:0] mark;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0:       mark = shadow_cfg.mark_min;
            1:       mark = shadow_cfg.mark_low;
            default: mark = shadow_cfg.mark_high;
        endcase
        if (roll < 40) return mark + FILL_W'($urandom_range(0, 4)) - FILL_W'(2);
        if (roll < 48) return '0;
        if (roll < 55) return '1;
        if (roll < 80) return FILL_W'($urandom_range(0, 65535));
        return FILL_W'($urandom_range(0, 511));
    endfunction

    // Predictor: all three comparisons use the count recorded before this
    // word; records come out min, low, high and the last one is marked.
    function automatic int predict_crossings(in_item_t w, bit publish);
        logic [FILL_W-1:0] prior;
        logic [FILL_W-1:0] lvl;
        int                n;
        n = 0;
        if (!shadow_cfg.enable) return 0;
        prior = last_count[w.channel];
        for (int k = 0; k < NUM_MARKS; k++) begin
            case (k)
                0:       lvl = shadow_cfg.mark_min;
                1:       lvl = shadow_cfg.mark_low;
                default: lvl = shadow_cfg.mark_high;
            endcase
            if ((w.fill_count < lvl && prior > lvl) ||
                (w.fill_count > lvl && prior < lvl)) begin
                if (publish) pending_records.push_back('{w.queue_id, w.fill_count, 1'b0});
                n++;
            end
        end
        if (n > 0) begin
            if (publish) pending_records[pending_records.size()-1].last_record = 1'b1;
            last_count[w.channel] = w.fill_count;
        end
        return n;
    endfunction

    // Offer one word after an optional gap; returns at the accepting edge
    task automatic send_report(in_item_t w);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Drop valid, let every expected record out, then let any word without
    // crossings clear the pipeline before registers are touched.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_records.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_ENABLE:    shadow_cfg.enable    = value[0];
            REG_MARK_MIN:  shadow_cfg.mark_min  = value[FILL_W-1:0];
            REG_MARK_LOW:  shadow_cfg.mark_low  = value[FILL_W-1:0];
            REG_MARK_HIGH: shadow_cfg.mark_high = value[FILL_W-1:0];
        endcase
        settings++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // New marks for a random phase: spread out, bunched, at the limits, or small
    task automatic new_marks();
        int                style;
        logic [FILL_W-1:0] base;
        logic [FILL_W-1:0] m [NUM_MARKS];
        style = $urandom_range(0, 3);
        base  = FILL_W'($urandom_range(0, 65000));
        for (int k = 0; k < NUM_MARKS; k++) begin
            case (style)
                0: m[k] = FILL_W'($urandom_range(0, 65535));
                1: m[k] = base + FILL_W'($urandom_range(0, 12));
                2: begin
                    case ($urandom_range(0, 2))
                        0:       m[k] = '0;
                        1:       m[k] = '1;
                        default: m[k] = FILL_W'($urandom_range(1, 65534));
                    endcase
                end
                default: m[k] = FILL_W'($urandom_range(0, 600));
            endcase
        end
        reg_write(REG_MARK_MIN,  DATA_W'(m[0]));
        reg_write(REG_MARK_LOW,  DATA_W'(m[1]));
        reg_write(REG_MARK_HIGH, DATA_W'(m[2]));
    endtask

    // Receiver: random m_ready gaps, plus the long hold when asked for.
    // Only one assignment to m_ready per falling edge.
    initial begin : drain_records
        int low_n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            low_n = pick_gap();
            if (hold_asked != 0) begin
                hold_asked = 0;
                low_n += LONG_HOLD;
            end
            if (low_n > 0) begin
                m_ready <= 1'b0;
                repeat (low_n) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Record checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin : check_records
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $error("unexpected record: queue %0d count %0d last %0b",
                       m_data.rec_queue_id, m_data.rec_count, m_data.last_record);
                mismatches++;
            end else begin
                want = pending_records.pop_front();
                records_checked++;
                if (m_data.rec_queue_id !== want.rec_queue_id) begin
                    $error("rec_queue_id: expected %0d, got %0d",
                           want.rec_queue_id, m_data.rec_queue_id);
                    mismatches++;
                end
                if (m_data.rec_count !== want.rec_count) begin
                    $error("rec_count: expected %0d, got %0d",
                           want.rec_count, m_data.rec_count);
                    mismatches++;
                end
                if (m_data.last_record !== want.last_record) begin
                    $error("last_record: expected %0b, got %0b",
                           want.last_record, m_data.last_record);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial begin : stimulus
        in_item_t w;
        int       n;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        aresetn = 1'b0;
        shadow_cfg = '{1'b0, MARK_MIN_RST, MARK_LOW_RST, MARK_HIGH_RST};
        foreach (last_count[c]) last_count[c] = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table. Typed rows still run the predictor so that the
        // recorded counts stay in step for the rows that follow.
        for (int r = 0; r < ROWS; r++) begin
            if (plan[r].kind == ROW_REG) begin
                wait_idle();
                reg_write(plan[r].idx, plan[r].value);
            end else begin
                w = '{plan[r].ch, plan[r].qid, plan[r].fill};
                send_report(w);
                n = predict_crossings(w, plan[r].typed_n == PREDICT);
                for (int j = 0; j < plan[r].typed_n; j++)
                    pending_records.push_back('{w.queue_id, w.fill_count,
                                                j == plan[r].typed_n - 1});
            end
        end

        // Random phases; phase 1 also carries the long receiver hold with
        // the sender running flat out so that the entry queue fills.
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            new_marks();
            calm = (p == 1 || p == 3 || p == 6);
            if (p == 1) hold_asked = 1;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                w.channel    = CHAN_W'($urandom_range(0, CHANNELS_DEF - 1));
                w.queue_id   = QID_W'($urandom_range(0, 16383));
                w.fill_count = pick_fill();
                send_report(w);
                n = predict_crossings(w, 1'b1);
            end
        end

        calm = 1'b0;
        wait_idle();
        $display("run covered %0d report words and %0d crossing records", words_sent,
                 records_checked);
        $display("across %0d register writes and %0d random mark settings", settings,
                 PHASES);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
